[rtl/cdq_pkg.sv]
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // Value returned by a pop from an empty queue.
   localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_READ = 2'd1,
      CTL_RESP = 2'd2
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // A request is taken in this cycle.
      logic capture;   // Load the slot read data into the result register.
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_read;   // The offered request is a pop of a nonempty queue.
   } dp_status_type;

endpackage

[rtl/cdq_ifs.sv]
// Request and response channel interfaces of the circular double-ended queue.
interface cdq_req_if;
   logic                               valid;
   logic                               ready;
   logic [cdq_pkg::OP_W-1:0]           op;
   logic signed [cdq_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cdq_pkg::DATA_W-1:0]  pop_value;
   logic [cdq_pkg::STATUS_W-1:0]       status;
   logic                               now_empty;
   logic                               now_full;

   modport source (output valid, output pop_value, output status, output now_empty,
                   output now_full, input ready);
   modport sink   (input valid, input pop_value, input status, input now_empty,
                   input now_full, output ready);
endinterface

[rtl/cdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cdq_ctrl.sv]
// Controller state machine of the circular double-ended queue.
module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  cdq_pkg::dp_status_type stat,
   output cdq_pkg::ctl_cmd_type  cmd
);

   cdq_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::CTL_IDLE: begin
            if (req_valid) begin
               state_in = stat.needs_read ? cdq_pkg::CTL_READ : cdq_pkg::CTL_RESP;
            end
         end
         cdq_pkg::CTL_READ: begin
            state_in = cdq_pkg::CTL_RESP;
         end
         cdq_pkg::CTL_RESP: begin
            if (rsp_ready) begin
               state_in = cdq_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = cdq_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         cdq_pkg::CTL_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         cdq_pkg::CTL_READ: begin
            cmd.capture = 1'b1;
         end
         cdq_pkg::CTL_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A pop that reads a slot always passes through the read state.
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.needs_read) |=> state_ff == cdq_pkg::CTL_READ)
      else $error("pop with slot read did not enter the read state");

   // The read state always leads straight to the response state.
   a_read_to_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdq_pkg::CTL_READ) |=> state_ff == cdq_pkg::CTL_RESP)
      else $error("read state did not lead to the response state");

   // No request is taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a response is pending");

endmodule

[rtl/cdq_datapath.sv]
// Datapath of the circular double-ended queue: indices, slot RAM and result register.
module cdq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::ctl_cmd_type              cmd,
   output cdq_pkg::dp_status_type            stat,
   input  logic [cdq_pkg::OP_W-1:0]          op,
   input  logic [cdq_pkg::DATA_W-1:0]        push_value,
   output logic [cdq_pkg::DATA_W-1:0]        pop_value,
   output logic [cdq_pkg::STATUS_W-1:0]      status,
   output logic                              now_empty,
   output logic                              now_full
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
      return (i >= LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] prev_idx(input logic [IW-1:0] i);
      return (i == '0 || i > LAST_IDX) ? LAST_IDX : i - 1'b1;
   endfunction

   logic [IW-1:0]                 front_ff, front_in;
   logic [IW-1:0]                 rear_ff, rear_in;
   logic                          empty_ff, empty_in;
   logic [cdq_pkg::DATA_W-1:0]    value_ff, value_in;
   cdq_pkg::status_type           status_ff, status_in;
   logic                          now_empty_ff;
   logic                          now_full_ff, full_after;

   cdq_pkg::op_type               op_code;
   logic                          is_push;
   logic                          full_now;
   logic                          ram_we, ram_re;
   logic [IW-1:0]                 ram_waddr, ram_raddr;
   logic [cdq_pkg::DATA_W-1:0]    ram_rdata;

   assign op_code  = cdq_pkg::op_type'(op);
   assign is_push  = (op_code == cdq_pkg::OP_PUSH_FRONT) ||
                     (op_code == cdq_pkg::OP_PUSH_REAR);
   assign full_now = !empty_ff && (next_idx(rear_ff) == front_ff);
   assign stat.needs_read = !is_push && !empty_ff;

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      empty_in  = empty_ff;
      value_in  = '0;
      status_in = cdq_pkg::ST_DONE;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = '0;
      ram_raddr = front_ff;
      if (is_push) begin
         if (full_now) begin
            status_in = cdq_pkg::ST_FULL;
         end else if (empty_ff) begin
            // First entry always lands in slot zero.
            front_in = '0;
            rear_in  = '0;
            empty_in = 1'b0;
            ram_we   = cmd.accept;
         end else if (op_code == cdq_pkg::OP_PUSH_FRONT) begin
            front_in  = prev_idx(front_ff);
            ram_waddr = prev_idx(front_ff);
            ram_we    = cmd.accept;
         end else begin
            rear_in   = next_idx(rear_ff);
            ram_waddr = next_idx(rear_ff);
            ram_we    = cmd.accept;
         end
      end else begin
         if (empty_ff) begin
            value_in  = cdq_pkg::POP_EMPTY_VALUE;
            status_in = cdq_pkg::ST_EMPTY;
         end else begin
            ram_re    = cmd.accept;
            ram_raddr = (op_code == cdq_pkg::OP_POP_FRONT) ? front_ff : rear_ff;
            if (front_ff == rear_ff) begin
               // Last entry leaves: indices return to zero.
               front_in = '0;
               rear_in  = '0;
               empty_in = 1'b1;
            end else if (op_code == cdq_pkg::OP_POP_FRONT) begin
               front_in = next_idx(front_ff);
            end else begin
               rear_in = prev_idx(rear_ff);
            end
         end
      end
      full_after = !empty_in && (next_idx(rear_in) == front_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff     <= value_in;
         status_ff    <= status_in;
         now_empty_ff <= empty_in;
         now_full_ff  <= full_after;
      end else if (cmd.capture) begin
         value_ff <= ram_rdata;
      end
   end

   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (push_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pop_value = value_ff;
   assign status    = status_ff;
   assign now_empty = now_empty_ff;
   assign now_full  = now_full_ff;

   // An empty queue always has both indices parked at zero.
   a_empty_parks: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0 && rear_ff == '0))
      else $error("empty queue with nonzero index");

   // Slots are written only by an accepted push.
   a_write_on_push: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd.accept && is_push && !full_now))
      else $error("slot write outside an accepted push");

   // Indices move only when a request is taken.
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.accept) && !$past(reset) |-> $stable(front_ff) && $stable(rear_ff))
      else $error("index changed without an accepted request");

endmodule

[rtl/circular_double_ended_queue.sv]
// Top level of the circular double-ended queue: controller, datapath and channels.
//
// The block keeps up to DEPTH signed 32-bit entries in a ring held in a RAM.
// Each request on req_ch carries an op (push front, push rear, pop front,
// pop rear) and a push_value. Every request yields exactly one response on
// rsp_ch with pop_value, status (done, push refused because full, pop refused
// because empty) and the now_empty and now_full flags after the step.
// A push answers with pop_value zero; a pop of an empty queue answers all ones.
//
// One request is in flight at a time. A push or a refused pop shows its
// response in the cycle after the request is taken; a pop that reads a slot
// first passes through the read state for the registered RAM read, and a
// new request is taken only after the response has been delivered.
//
// A response waits in the output register while rsp_ch.ready is low, and no
// new request is taken until it is delivered. Synchronous reset returns the
// controller to idle and the queue to empty with both indices at zero; the
// slot contents are left as they were and are never read before a push.
module circular_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   cdq_req_if.sink  req_ch,
   cdq_rsp_if.source rsp_ch
);

   cdq_pkg::ctl_cmd_type   cmd;
   cdq_pkg::dp_status_type stat;

   // The controller sequences accept, optional slot read and response.
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath updates the indices when a request is taken and holds the response.
   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .op         (req_ch.op),
      .push_value (req_ch.push_value),
      .pop_value  (rsp_ch.pop_value),
      .status     (rsp_ch.status),
      .now_empty  (rsp_ch.now_empty),
      .now_full   (rsp_ch.now_full)
   );

endmodule

[tb/sv/circular_double_ended_queue_tb.sv]
// Self-checking testbench for the circular double-ended queue: stimulus, prediction and checks.
module circular_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   localparam int QDEPTH     = 16;
   localparam int RANDOM_REQ = 625;

   // One request waiting to be driven. The lead is the number of idle cycles the
   // sender spends before offering it. With settle set, the sender first waits
   // until every owed response has been delivered.
   typedef struct {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      int                        lead;
      bit                        settle;
   } deque_req_type;

   // Fields of one predicted response.
   typedef struct {
      logic signed [DATA_W-1:0]  pop_value;
      status_type                status;
      logic                      now_empty;
      logic                      now_full;
   } deque_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdq_req_if req_ch();
   cdq_rsp_if rsp_ch();

   circular_double_ended_queue #(.DEPTH(QDEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   deque_req_type request_backlog[$];
   deque_rsp_type owed_responses[$];

   int total_requests  = 0;
   int requests_taken  = 0;
   int responses_seen  = 0;
   int mismatch_count  = 0;
   int lead_count      = 0;
   int stall_left      = 0;
   int refused_pushes  = 0;
   int empty_pops      = 0;
   int full_responses  = 0;

   // Shadow copy of the ring. Slots are only read after a push wrote them.
   logic signed [DATA_W-1:0] ring [QDEPTH];
   int front_at   = 0;
   int rear_at    = 0;
   bit ring_empty = 1'b1;

   function automatic int ring_next(int i);
      return (i == QDEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int ring_prev(int i);
      return (i == 0) ? QDEPTH - 1 : i - 1;
   endfunction

   // Full means not empty and the slot after the rear is the front.
   function automatic bit ring_full();
      return !ring_empty && ring_next(rear_at) == front_at;
   endfunction

   // Applies one request to the shadow ring and returns the response it owes.
   function automatic deque_rsp_type apply_deque_op(op_type op,
                                                    logic signed [DATA_W-1:0] value);
      deque_rsp_type r;
      int at;
      r.pop_value = '0;
      r.status    = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
         if (ring_full()) begin
            r.status = ST_FULL;
         end else if (ring_empty) begin
            // A push into an empty queue always lands in slot zero.
            front_at   = 0;
            rear_at    = 0;
            ring_empty = 1'b0;
            ring[0]    = value;
         end else if (op == OP_PUSH_FRONT) begin
            front_at       = ring_prev(front_at);
            ring[front_at] = value;
         end else begin
            rear_at       = ring_next(rear_at);
            ring[rear_at] = value;
         end
      end else begin
         if (ring_empty) begin
            r.pop_value = POP_EMPTY_VALUE;
            r.status    = ST_EMPTY;
         end else begin
            at          = (op == OP_POP_FRONT) ? front_at : rear_at;
            r.pop_value = ring[at];
            if (front_at == rear_at) begin
               // The last entry leaves: both indices return to zero.
               front_at   = 0;
               rear_at    = 0;
               ring_empty = 1'b1;
            end else if (op == OP_POP_FRONT) begin
               front_at = ring_next(front_at);
            end else begin
               rear_at = ring_prev(rear_at);
            end
         end
      end
      r.now_empty = ring_empty;
      r.now_full  = ring_full();
      return r;
   endfunction

   // Idle cycles before the n-th request or response. The pattern cycles through
   // a stretch with no idling, a stretch of uniformly drawn idling, and a stretch
   // where idling is occasional, so gaps land on every phase of the block's work.
   function automatic int draw_idle(int n);
      case ((n / 50) % 3)
         0:       return 0;
         1:       return $urandom_range(0, 9);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      endcase
   endfunction

   task automatic add_request(op_type op, logic signed [DATA_W-1:0] value, bit settle);
      deque_req_type q;
      q.op     = op;
      q.value  = value;
      q.lead   = draw_idle(total_requests);
      q.settle = settle;
      request_backlog.push_back(q);
      total_requests++;
   endtask

   // Sender. When the channel is free (nothing offered, or the offered request
   // was taken at this edge) the next request is offered after its lead cycles.
   // A request that is taken is predicted at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         // Nothing is offered during reset, and the payload holds known values.
         req_ch.valid      <= 1'b0;
         req_ch.op         <= OP_PUSH_FRONT;
         req_ch.push_value <= '0;
         lead_count = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            owed_responses.push_back(apply_deque_op(op_type'(req_ch.op), req_ch.push_value));
            requests_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (request_backlog.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (request_backlog[0].settle && owed_responses.size() != 0) begin
               // Hold off until the block has answered everything in flight.
               req_ch.valid <= 1'b0;
            end else if (lead_count < request_backlog[0].lead) begin
               lead_count++;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.op         <= request_backlog[0].op;
               req_ch.push_value <= request_backlog[0].value;
               req_ch.valid      <= 1'b1;
               void'(request_backlog.pop_front());
               lead_count = 0;
            end
         end
      end
   end

   // Receiver. Each delivered response is compared field by field with the
   // oldest expectation, then a new stall is drawn for the next one.
   always @(posedge clock) begin : watch_responses
      deque_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_responses.size() == 0) begin
               $error("response with no request waiting: pop_value %0d status %0d",
                      rsp_ch.pop_value, rsp_ch.status);
               mismatch_count++;
            end else begin
               want = owed_responses.pop_front();
               if (rsp_ch.pop_value !== want.pop_value) begin
                  $error("pop_value: expected %0d, got %0d", want.pop_value, rsp_ch.pop_value);
                  mismatch_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  mismatch_count++;
               end
               if (rsp_ch.now_empty !== want.now_empty) begin
                  $error("now_empty: expected %0d, got %0d", want.now_empty, rsp_ch.now_empty);
                  mismatch_count++;
               end
               if (rsp_ch.now_full !== want.now_full) begin
                  $error("now_full: expected %0d, got %0d", want.now_full, rsp_ch.now_full);
                  mismatch_count++;
               end
               if (want.status == ST_FULL)  refused_pushes++;
               if (want.status == ST_EMPTY) empty_pops++;
               if (want.now_full)           full_responses++;
            end
            responses_seen++;
            stall_left = draw_idle(responses_seen);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int   mode;
      int   seg_left;
      int   push_pct;
      op_type op;
      logic signed [DATA_W-1:0] value;

      // Directed part. Pops of an empty queue from both ends come first.
      add_request(OP_POP_FRONT, 32'sd0, 1'b0);
      add_request(OP_POP_REAR, 32'sh7FFF_FFFF, 1'b0);
      // A push into the empty queue lands in slot zero; a front push then
      // wraps the front index below zero to the top slot.
      add_request(OP_PUSH_FRONT, 32'sh8000_0000, 1'b0);
      add_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b0);
      // A rear pop from slot zero wraps to the top slot, leaving one entry;
      // the front pop then takes the last entry and the queue is empty again.
      add_request(OP_POP_REAR, 32'sd0, 1'b0);
      add_request(OP_POP_FRONT, -32'sd1, 1'b0);
      // Fill the queue from both ends with bit patterns and extremes.
      for (int i = 0; i < QDEPTH; i++) begin
         case (i % 4)
            0:       value = 32'shAAAA_AAAA;
            1:       value = 32'sh5555_5555;
            2:       value = (i < 8) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: value = (i < 8) ? -32'sd1 : 32'sd0;
         endcase
         add_request((i % 3 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, value, 1'b0);
      end
      // Pushes into a full queue are refused at either end.
      add_request(OP_PUSH_FRONT, 32'sd12345, 1'b0);
      add_request(OP_PUSH_REAR, -32'sd12345, 1'b0);
      add_request(OP_POP_FRONT, 32'sd0, 1'b0);

      // Random part, in segments that lean toward pushes, toward pops, or
      // neither, so the queue swings between full and empty many times.
      // The first random request waits for the directed part to drain, and a
      // few more further on do the same.
      seg_left = 0;
      push_pct = 50;
      for (int n = 0; n < RANDOM_REQ; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 40);
            mode     = $urandom_range(0, 2);
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
         end
         seg_left--;
         if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
         else
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0:       value = 32'sd0;
               1:       value = -32'sd1;
               2:       value = 32'sh7FFF_FFFF;
               default: value = 32'sh8000_0000;
            endcase
         end else begin
            value = $urandom;
         end
         add_request(op, value, n % 200 == 0);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until everything was sent and answered, then give the block a
      // few more cycles to show any stray response.
      while (request_backlog.size() != 0 || requests_taken != total_requests ||
             owed_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d requests through a %0d-entry queue: %0d pushes refused as full,",
               requests_taken, QDEPTH, refused_pushes);
      $display("%0d pops refused as empty, %0d responses reported the queue full.",
               empty_pops, full_responses);
      if (mismatch_count == 0 && owed_responses.size() == 0) begin
         $display("circular_double_ended_queue_tb passed");
      end else begin
         $display("circular_double_ended_queue_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("circular_double_ended_queue_tb failed");
      $finish;
   end

endmodule

[sim.f]
rtl/cdq_pkg.sv
rtl/cdq_ifs.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_double_ended_queue.sv
tb/sv/circular_double_ended_queue_tb.sv
